// ===== sv/rf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_pkg: shared types and constants of the 3x3 rank filter
// pixel and window types, per-request side data, mode and register codes
// ----------------------------------------------------------------------------
package rf_pkg;

	parameter int PIX_W        = 8;
	parameter int N_TAPS       = 9;
	parameter int RANK_W       = 4;
	parameter int MEDIAN_RANK  = 4;
	parameter int MIN_DIM      = 3;
	parameter int ROW_W        = 12;
	parameter int H_W          = 13;
	parameter int IW_W         = 11;
	parameter int HEIGHT_LIMIT = 4096;
	parameter int MODE_W       = 2;
	parameter int CFG_W        = 13;
	parameter int CFG_IDX_W    = 2;

	// filter modes
	parameter logic [MODE_W-1:0] MODE_MIN = 2'd0;
	parameter logic [MODE_W-1:0] MODE_MAX = 2'd1;
	parameter logic [MODE_W-1:0] MODE_MED = 2'd2;

	// configuration register indexes
	parameter logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	parameter logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	parameter logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	parameter logic [MODE_W-1:0] MODE_RESET   = MODE_MED;
	parameter logic [IW_W-1:0]   WIDTH_RESET  = 11'd640;
	parameter logic [H_W-1:0]    HEIGHT_RESET = 13'd480;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [N_TAPS-1:0][PIX_W-1:0] win_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic              last;
	} meta_t;

endpackage

// ===== sv/rf_pix_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_pix_if: pixel input channel
// valid/ready channel carrying one raster pixel and its frame start mark
// ----------------------------------------------------------------------------
interface rf_pix_if;
	logic         valid;
	logic         ready;
	rf_pkg::pix_t pixel;
	logic         frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// ===== sv/rf_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_res_if: filter result channel
// valid/ready channel carrying one filtered pixel and its end of frame mark
// ----------------------------------------------------------------------------
interface rf_res_if;
	logic         valid;
	logic         ready;
	rf_pkg::pix_t filtered_value;
	logic         last_of_frame;

	modport source (output valid, output filtered_value, output last_of_frame, input ready);
	modport sink   (input valid, input filtered_value, input last_of_frame, output ready);
endinterface

// ===== sv/rank_filter_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_filter_3x3: streaming 3x3 minimum / maximum / median filter
// line stores and window front end, a chain of sort cells, output register
// ----------------------------------------------------------------------------
// Takes one 8-bit pixel per clock in raster order and gives, for every
// interior pixel, the minimum, maximum or median of its 3x3 neighborhood
// (mode register 0, 1, 2; mode 3 gives nothing). Border pixels give no
// result; the last interior pixel of a frame carries last_of_frame. A
// request with frame_start set is taken as row 0, column 0. Throughput is
// one pixel per clock as long as the output side keeps taking results and
// the line stores are not being cleared. The store read register is loaded
// at the accepting edge itself; a result then passes the window register,
// the nine sort cells of odd-even transposition sort and the output register.
// After reset the two line stores are cleared one entry per cycle, which
// holds pixel ready low until the clearing pass ends; configuration writes are
// taken throughout. Change the configuration only while the block is idle.
// ----------------------------------------------------------------------------
module rank_filter_3x3 #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rf_pkg::CFG_W-1:0]       cfg_data,
	rf_pix_if.sink                         pixels,
	rf_res_if.source                       results
);

	// configuration registers
	logic [rf_pkg::MODE_W-1:0] mode_q;
	logic [rf_pkg::IW_W-1:0]   width_q;
	logic [rf_pkg::H_W-1:0]    height_q;

	// chain of stages: index 0 is the window, index k+1 the output of cell k
	rf_pkg::win_t  vec_c  [rf_pkg::N_TAPS+1];
	rf_pkg::meta_t meta_c [rf_pkg::N_TAPS+1];
	logic          v_c    [rf_pkg::N_TAPS+1];
	logic          en_c   [rf_pkg::N_TAPS+1];

	// output register
	logic          out_v_q;
	rf_pkg::pix_t  val_q;
	logic          last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= rf_pkg::MODE_RESET;
			width_q  <= rf_pkg::WIDTH_RESET;
			height_q <= rf_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rf_pkg::REG_MODE:   mode_q   <= cfg_data[rf_pkg::MODE_W-1:0];
				rf_pkg::REG_WIDTH:  width_q  <= cfg_data[rf_pkg::IW_W-1:0];
				rf_pkg::REG_HEIGHT: height_q <= cfg_data[rf_pkg::H_W-1:0];
				default: ;  // no register there
			endcase
		end
	end

	// line stores, counters and the 3x3 window
	rf_window #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (mode_q),
		.image_width  (width_q),
		.image_height (height_q),
		.in_valid     (pixels.valid),
		.in_ready     (pixels.ready),
		.pixel        (pixels.pixel),
		.frame_start  (pixels.frame_start),
		.down_en      (en_c[0]),
		.win_valid    (v_c[0]),
		.win          (vec_c[0]),
		.meta         (meta_c[0])
	);

	// nine rounds fully sort the nine window values
	for (genvar k = 0; k < rf_pkg::N_TAPS; k++) begin : g_cell
		rf_sort_cell #(
			.PHASE (k % 2)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (v_c[k]),
			.up_vec   (vec_c[k]),
			.up_meta  (meta_c[k]),
			.up_en    (en_c[k]),
			.down_en  (en_c[k+1]),
			.valid    (v_c[k+1]),
			.vec      (vec_c[k+1]),
			.meta     (meta_c[k+1])
		);
	end

	// output register stalls the chain while a result waits
	assign en_c[rf_pkg::N_TAPS] = !out_v_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_c[rf_pkg::N_TAPS]) begin
			out_v_q <= v_c[rf_pkg::N_TAPS];
		end
	end

	// pick the requested rank out of the sorted row
	always_ff @(posedge clk) begin
		if (en_c[rf_pkg::N_TAPS] && v_c[rf_pkg::N_TAPS]) begin
			val_q  <= vec_c[rf_pkg::N_TAPS][meta_c[rf_pkg::N_TAPS].rank];
			last_q <= meta_c[rf_pkg::N_TAPS].last;
		end
	end

	assign results.valid          = out_v_q;
	assign results.filtered_value = val_q;
	assign results.last_of_frame  = last_q;

endmodule

// ===== sv/rf_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_window: line stores, position counters and 3x3 window
// two stage front end: store read in s1, window shift in s2
// ----------------------------------------------------------------------------
module rf_window #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rf_pkg::MODE_W-1:0]     mode,
	input  logic [rf_pkg::IW_W-1:0]       image_width,
	input  logic [rf_pkg::H_W-1:0]        image_height,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  rf_pkg::pix_t                  pixel,
	input  logic                          frame_start,
	input  logic                          down_en,
	output logic                          win_valid,
	output rf_pkg::win_t                  win,
	output rf_pkg::meta_t                 meta
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WW    = COL_W + 1;

	logic                       clr_busy_q;
	logic [COL_W-1:0]           clr_addr_q;
	logic [COL_W-1:0]           col_q;
	logic [rf_pkg::ROW_W-1:0]   row_q;

	logic [WW-1:0]              w_eff;
	logic [rf_pkg::H_W-1:0]     h_eff;
	logic [COL_W-1:0]           col_cur;
	logic [rf_pkg::ROW_W-1:0]   row_cur;
	logic [WW-1:0]              col_inc;
	logic [rf_pkg::H_W-1:0]     row_inc;
	logic                       emit;
	logic                       last;
	logic [rf_pkg::RANK_W-1:0]  rank;

	logic                       acc;
	logic                       en_s1;
	logic                       en_s2;
	logic                       adv_s1;
	logic                       fwd_hit;

	logic                       v_s1_q;
	logic [COL_W-1:0]           col_s1;
	rf_pkg::pix_t               px_s1;
	rf_pkg::pix_t               rd_lo_s1;
	rf_pkg::pix_t               rd_up_s1;
	logic                       fwd_s1;
	rf_pkg::pix_t               fwd_dat_s1;
	logic                       emit_s1;
	rf_pkg::meta_t              meta_s1;
	rf_pkg::pix_t               up_s1;

	logic                       v_s2_q;
	logic                       emit_s2;
	rf_pkg::meta_t              meta_s2;
	rf_pkg::win_t               win_s2;

	logic                       up_we;
	logic [COL_W-1:0]           up_addr;
	rf_pkg::pix_t               up_dat;

	rf_pkg::pix_t               lo_mem [MAX_WIDTH];
	rf_pkg::pix_t               up_mem [MAX_WIDTH];

	// effective frame size
	always_comb begin
		if (image_width < rf_pkg::IW_W'(rf_pkg::MIN_DIM)) begin
			w_eff = WW'(rf_pkg::MIN_DIM);
		end else if (32'(image_width) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(image_width);
		end
		if (image_height < rf_pkg::H_W'(rf_pkg::MIN_DIM)) begin
			h_eff = rf_pkg::H_W'(rf_pkg::MIN_DIM);
		end else if (32'(image_height) > rf_pkg::HEIGHT_LIMIT) begin
			h_eff = rf_pkg::H_W'(rf_pkg::HEIGHT_LIMIT);
		end else begin
			h_eff = image_height;
		end
	end

	// position of the incoming pixel
	assign col_cur = frame_start ? '0 : col_q;
	assign row_cur = frame_start ? '0 : row_q;
	assign col_inc = {1'b0, col_cur} + WW'(1);
	assign row_inc = {1'b0, row_cur} + rf_pkg::H_W'(1);

	assign emit = (row_cur >= rf_pkg::ROW_W'(2)) && (col_cur >= COL_W'(2))
		&& ({1'b0, row_cur} < h_eff) && ({1'b0, col_cur} < w_eff)
		&& (mode != ~rf_pkg::MODE_W'(0));
	assign last = ({1'b0, row_cur} == h_eff - rf_pkg::H_W'(1))
		&& ({1'b0, col_cur} == w_eff - WW'(1));

	always_comb begin
		unique case (mode)
			rf_pkg::MODE_MIN: rank = '0;
			rf_pkg::MODE_MAX: rank = rf_pkg::RANK_W'(rf_pkg::N_TAPS - 1);
			rf_pkg::MODE_MED: rank = rf_pkg::RANK_W'(rf_pkg::MEDIAN_RANK);
			default:          rank = '0;
		endcase
	end

	// handshake chain
	assign en_s2    = !v_s2_q || !emit_s2 || down_en;
	assign adv_s1   = v_s1_q && en_s2;
	assign en_s1    = !v_s1_q || en_s2;
	assign in_ready = en_s1 && !clr_busy_q;
	assign acc      = in_valid && in_ready;
	assign fwd_hit  = adv_s1 && (col_cur == col_s1);

	// counters and clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + COL_W'(1);
				if (clr_addr_q == COL_W'(MAX_WIDTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (acc) begin
				if (col_inc >= w_eff) begin
					col_q <= '0;
					row_q <= (row_inc >= h_eff) ? '0 : row_inc[rf_pkg::ROW_W-1:0];
				end else begin
					col_q <= col_inc[COL_W-1:0];
					row_q <= row_cur;
				end
			end
		end
	end

	// lower store: new pixel written on request
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			lo_mem[clr_addr_q] <= '0;
		end else if (acc) begin
			lo_mem[col_cur] <= pixel;
		end
		if (acc) begin
			rd_lo_s1 <= lo_mem[col_cur];
		end
	end

	// upper store: takes the old lower entry when s1 moves on
	assign up_we   = clr_busy_q || adv_s1;
	assign up_addr = clr_busy_q ? clr_addr_q : col_s1;
	assign up_dat  = clr_busy_q ? '0 : rd_lo_s1;

	always_ff @(posedge clk) begin
		if (up_we) begin
			up_mem[up_addr] <= up_dat;
		end
		if (acc) begin
			rd_up_s1 <= up_mem[col_cur];
		end
	end

	// s1 valid and side data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (en_s1) begin
			v_s1_q <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1       <= col_cur;
			px_s1        <= pixel;
			fwd_s1       <= fwd_hit;
			fwd_dat_s1   <= rd_lo_s1;
			emit_s1      <= emit;
			meta_s1.rank <= rank;
			meta_s1.last <= last;
		end
	end

	// same column twice in a row: upper write still in flight
	assign up_s1 = fwd_s1 ? fwd_dat_s1 : rd_up_s1;

	// s2: the window itself
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2_q <= 1'b0;
			win_s2 <= '0;
		end else if (en_s2) begin
			v_s2_q <= v_s1_q;
			if (v_s1_q) begin
				win_s2[0] <= win_s2[1];
				win_s2[1] <= win_s2[2];
				win_s2[2] <= up_s1;
				win_s2[3] <= win_s2[4];
				win_s2[4] <= win_s2[5];
				win_s2[5] <= rd_lo_s1;
				win_s2[6] <= win_s2[7];
				win_s2[7] <= win_s2[8];
				win_s2[8] <= px_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			emit_s2 <= emit_s1;
			meta_s2 <= meta_s1;
		end
	end

	assign win_valid = v_s2_q && emit_s2;
	assign win       = win_s2;
	assign meta      = meta_s2;

endmodule

// ===== sv/rf_sort_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_sort_cell: one round of odd-even transposition sort
// compare-exchanges neighbor pairs starting at PHASE and registers the row
// ----------------------------------------------------------------------------
module rf_sort_cell #(
	parameter int PHASE = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	input  rf_pkg::win_t  up_vec,
	input  rf_pkg::meta_t up_meta,
	output logic          up_en,
	input  logic          down_en,
	output logic          valid,
	output rf_pkg::win_t  vec,
	output rf_pkg::meta_t meta
);

	logic          v_q;
	rf_pkg::win_t  vec_q;
	rf_pkg::meta_t meta_q;
	rf_pkg::win_t  swp;

	// disjoint pairs, so all exchanges are independent
	always_comb begin
		swp = up_vec;
		for (int i = PHASE; i + 1 < rf_pkg::N_TAPS; i += 2) begin
			if (up_vec[i] > up_vec[i+1]) begin
				swp[i]   = up_vec[i+1];
				swp[i+1] = up_vec[i];
			end
		end
	end

	assign up_en = !v_q || down_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_en) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_en && up_valid) begin
			vec_q  <= swp;
			meta_q <= up_meta;
		end
	end

	assign valid = v_q;
	assign vec   = vec_q;
	assign meta  = meta_q;

endmodule

// ===== sv/rf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_checker: port-level checks of the rank filter
// watches the pixel and result channels, bound to the top level
// ----------------------------------------------------------------------------
module rf_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input rf_pkg::pix_t out_value,
	input logic         out_last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
		else $error("result changed while stalled");

	// store clearing keeps the input closed and the output empty right after reset
	a_clear_after_reset: assert property (@(posedge clk)
		!$past(arst_n) && arst_n |-> !in_ready && !out_valid)
		else $error("block open right after reset");

	// once open, the input only closes on backpressure from the output
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_ready) && !in_ready |-> out_valid && !out_ready)
		else $error("input closed without output backpressure");

	// input valid is irrelevant to the checks above but kept visible for debug
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$isunknown(in_ready))
		else $error("input ready unknown after request");

endmodule

bind rank_filter_3x3 rf_checker u_rf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixels.valid),
	.in_ready  (pixels.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_value (results.filtered_value),
	.out_last  (results.last_of_frame)
);

// ===== tb/rank_filter_3x3_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_filter_3x3_tb: self-checking bench for the 3x3 rank filter
// drives raster pixel streams under several frame sizes and modes, predicts
// every interior result in a scoreboard and compares it field by field
// ----------------------------------------------------------------------------
module rank_filter_3x3_tb;

	localparam int LINE_DEPTH    = 1024;
	localparam int RANDOM_ITEMS  = 600;
	localparam int DRAIN_CYCLES  = 32;
	localparam int CYCLE_LIMIT   = 300000;

	// mode code that selects no rank, and the register index with no register
	localparam logic [rf_pkg::MODE_W-1:0]    MODE_NONE  = 2'd3;
	localparam logic [rf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		rf_pkg::pix_t value;
		logic         last;
	} rank_result_t;

	// predicts the filter output from the accepted pixel requests
	class rank_scoreboard;
		logic [rf_pkg::MODE_W-1:0] mode;
		logic [rf_pkg::IW_W-1:0]   width_reg;
		logic [rf_pkg::H_W-1:0]    height_reg;
		rf_pkg::pix_t              upper_row [LINE_DEPTH];
		rf_pkg::pix_t              lower_row [LINE_DEPTH];
		rf_pkg::pix_t              win [rf_pkg::N_TAPS];
		logic [9:0]                col_cnt;
		logic [rf_pkg::ROW_W-1:0]  row_cnt;
		rank_result_t              expected_by_seq [int];
		int                        put_idx;
		int                        get_idx;
		int                        errors;

		function new();
			mode       = rf_pkg::MODE_RESET;
			width_reg  = rf_pkg::WIDTH_RESET;
			height_reg = rf_pkg::HEIGHT_RESET;
			foreach (upper_row[i]) upper_row[i] = '0;
			foreach (lower_row[i]) lower_row[i] = '0;
			foreach (win[i]) win[i] = '0;
			col_cnt = '0;
			row_cnt = '0;
			put_idx = 0;
			get_idx = 0;
			errors  = 0;
		endfunction

		function void write_reg(logic [rf_pkg::CFG_IDX_W-1:0] idx,
			logic [rf_pkg::CFG_W-1:0] data);
			case (idx)
				rf_pkg::REG_MODE:   mode = data[rf_pkg::MODE_W-1:0];
				rf_pkg::REG_WIDTH:  width_reg = data[rf_pkg::IW_W-1:0];
				rf_pkg::REG_HEIGHT: height_reg = data[rf_pkg::H_W-1:0];
				default: ;
			endcase
		endfunction

		function int eff_width();
			int w;
			w = width_reg;
			if (w < rf_pkg::MIN_DIM) w = rf_pkg::MIN_DIM;
			if (w > LINE_DEPTH) w = LINE_DEPTH;
			return w;
		endfunction

		function int eff_height();
			int h;
			h = height_reg;
			if (h < rf_pkg::MIN_DIM) h = rf_pkg::MIN_DIM;
			if (h > rf_pkg::HEIGHT_LIMIT) h = rf_pkg::HEIGHT_LIMIT;
			return h;
		endfunction

		// value of the given rank among the nine window taps
		function rf_pkg::pix_t rank_of(int rank);
			rf_pkg::pix_t v [rf_pkg::N_TAPS];
			rf_pkg::pix_t key;
			int           i;
			int           j;
			foreach (win[k]) v[k] = win[k];
			for (i = 1; i < rf_pkg::N_TAPS; i++) begin
				key = v[i];
				j = i - 1;
				while (j >= 0 && v[j] > key) begin
					v[j + 1] = v[j];
					j--;
				end
				v[j + 1] = key;
			end
			return v[rank];
		endfunction

		function void note_input(rf_pkg::pix_t px, logic fs);
			int           w;
			int           h;
			int           c;
			int           r;
			rf_pkg::pix_t up;
			rf_pkg::pix_t mid;
			rank_result_t res;
			w = eff_width();
			h = eff_height();
			if (fs) begin
				col_cnt = '0;
				row_cnt = '0;
			end
			c = col_cnt;
			r = row_cnt;
			up  = upper_row[c];
			mid = lower_row[c];
			upper_row[c] = mid;
			lower_row[c] = px;
			win[0] = win[1]; win[1] = win[2]; win[2] = up;
			win[3] = win[4]; win[4] = win[5]; win[5] = mid;
			win[6] = win[7]; win[7] = win[8]; win[8] = px;
			if (r >= 2 && c >= 2 && r < h && c < w && mode != MODE_NONE) begin
				case (mode)
					rf_pkg::MODE_MIN: res.value = rank_of(0);
					rf_pkg::MODE_MAX: res.value = rank_of(rf_pkg::N_TAPS - 1);
					default:          res.value = rank_of(rf_pkg::MEDIAN_RANK);
				endcase
				res.last = (r == h - 1 && c == w - 1);
				expected_by_seq[put_idx] = res;
				put_idx++;
			end
			if (c + 1 >= w) begin
				col_cnt = '0;
				row_cnt = (r + 1 >= h) ? '0 : rf_pkg::ROW_W'(r + 1);
			end else begin
				col_cnt = 10'(c + 1);
			end
		endfunction

		function void check_result(rf_pkg::pix_t value, logic last);
			rank_result_t oldest;
			if (put_idx == get_idx) begin
				$error("unexpected result: filtered_value %0d last_of_frame %0d", value, last);
				errors++;
				return;
			end
			oldest = expected_by_seq[get_idx];
			expected_by_seq.delete(get_idx);
			get_idx++;
			if (value !== oldest.value) begin
				$error("filtered_value: expected %0d, actual %0d", oldest.value, value);
				errors++;
			end
			if (last !== oldest.last) begin
				$error("last_of_frame: expected %0d, actual %0d", oldest.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return put_idx - get_idx;
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [rf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rf_pkg::CFG_W-1:0]     cfg_data;

	rf_pix_if pix_ch ();
	rf_res_if res_ch ();

	rank_scoreboard sb;
	int idle_pct;
	int stall_pct;
	int cycle_cnt;

	rank_filter_3x3 #(
		.MAX_WIDTH(LINE_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixels   (pix_ch),
		.results  (res_ch)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver back-pressure, changed on the falling edge
	initial res_ch.ready = 1'b0;
	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// result monitor: one request per edge with valid and ready high
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.filtered_value, res_ch.last_of_frame);
	end

	// guard against a hung handshake
	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// idle and stall mix of a phase: none, sender, receiver, both
	task automatic set_traffic(int phase);
		case (phase % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 48; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 48; end
			default: begin idle_pct = 21; stall_pct = 21; end
		endcase
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_pixel(rf_pkg::pix_t px, logic fs);
		while ($urandom_range(0, 99) < idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pix_ch.valid       <= 1'b1;
		pix_ch.pixel       <= px;
		pix_ch.frame_start <= fs;
		do @(posedge clk); while (!pix_ch.ready);
		sb.note_input(px, fs);
		@(negedge clk);
	endtask

	// sender pauses until nothing is expected, then lets the pipe empty
	task automatic hold_until_drained(int extra);
		pix_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [rf_pkg::CFG_IDX_W-1:0] idx,
		logic [rf_pkg::CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		sb.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// new settings only once the filter has gone quiet
	task automatic configure(logic [rf_pkg::MODE_W-1:0] m, int w, int h);
		hold_until_drained(DRAIN_CYCLES);
		write_reg(rf_pkg::REG_MODE, rf_pkg::CFG_W'(m));
		write_reg(rf_pkg::REG_WIDTH, rf_pkg::CFG_W'(w));
		write_reg(rf_pkg::REG_HEIGHT, rf_pkg::CFG_W'(h));
	endtask

	task automatic send_row(rf_pkg::pix_t a, rf_pkg::pix_t b, rf_pkg::pix_t c,
		logic fs);
		send_pixel(a, fs);
		send_pixel(b, 1'b0);
		send_pixel(c, 1'b0);
	endtask

	function automatic rf_pkg::pix_t rand_pixel();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return 8'd0;
		if (sel == 1) return 8'd255;
		return rf_pkg::pix_t'($urandom_range(0, 255));
	endfunction

	// one frame or a piece of one; rare stray frame starts and pauses
	task automatic send_frame(bit with_start, int len);
		logic fs;
		for (int i = 0; i < len; i++) begin
			fs = (i == 0 && with_start) || ($urandom_range(0, 299) == 0);
			if ($urandom_range(0, 249) == 0)
				hold_until_drained(0);
			send_pixel(rand_pixel(), fs);
		end
	endtask

	initial begin
		int                        sent;
		int                        phase;
		int                        sel;
		int                        wv;
		int                        hv;
		int                        w;
		int                        h;
		int                        rows;
		int                        len;
		int                        frames;
		bit                        fresh;
		bit                        with_start;
		logic [rf_pkg::MODE_W-1:0] m;

		sb = new();
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		pix_ch.valid       = 1'b0;
		pix_ch.pixel       = '0;
		pix_ch.frame_start = 1'b0;
		idle_pct           = 0;
		stall_pct          = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: three-wide stream, tallest frame, counting from reset
		// without any frame start; three rows in min mode, then one row per mode
		set_traffic(0);
		configure(rf_pkg::MODE_MIN, 3, 8191);
		send_row(8'd255, 8'd0, 8'd17, 1'b0);
		send_row(8'd128, 8'd200, 8'd3, 1'b0);
		send_row(8'd90, 8'd255, 8'd1, 1'b0);
		configure(rf_pkg::MODE_MAX, 3, 8191);
		send_row(8'd254, 8'd255, 8'd0, 1'b0);
		configure(rf_pkg::MODE_MED, 3, 8191);
		send_row(8'd1, 8'd2, 8'd3, 1'b0);
		// mode with no rank: state moves on, nothing comes out
		configure(MODE_NONE, 3, 8191);
		send_row(8'd9, 8'd9, 8'd9, 1'b0);
		// sizes below the minimum act as 3x3, frame start at the start of a row
		configure(rf_pkg::MODE_MED, 2, 0);
		write_reg(REG_UNUSED, {rf_pkg::CFG_W{1'b1}});
		send_row(8'd7, 8'd200, 8'd13, 1'b1);
		send_row(8'd0, 8'd255, 8'd100, 1'b0);
		send_row(8'd42, 8'd42, 8'd42, 1'b0);

		// random phases, mostly small well-formed frames
		sent  = 0;
		phase = 1;
		while (sent < RANDOM_ITEMS) begin
			set_traffic(phase);
			phase++;
			sel = $urandom_range(0, 15);
			m   = (sel == 15) ? MODE_NONE : rf_pkg::MODE_W'(sel % 3);
			sel = $urandom_range(0, 11);
			wv  = (sel == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
			sel = $urandom_range(0, 11);
			case (sel)
				0: hv = $urandom_range(0, 2);
				1: hv = $urandom_range(4097, 8191);
				2: hv = 4096;
				default: hv = $urandom_range(3, 6);
			endcase
			configure(m, wv, hv);
			// a phase that starts without a frame start keeps the old
			// counters, which may lie beyond the new size
			fresh  = ($urandom_range(0, 3) != 0);
			frames = $urandom_range(1, 4);
			for (int f = 0; f < frames; f++) begin
				w    = sb.eff_width();
				h    = sb.eff_height();
				rows = (h > 8) ? $urandom_range(3, 8) : h;
				len  = w * rows;
				if ($urandom_range(0, 7) == 0)
					len = $urandom_range(1, len);
				with_start = (f == 0) ? fresh : (h > 8 || $urandom_range(0, 3) != 0);
				send_frame(with_start, len);
				sent += len;
			end
		end

		// widest rows: width above the limit acts as the line store depth,
		// so one full store row wraps the counters to row 1; a narrow frame
		// then carries on from there and gives a result on its second row
		set_traffic(phase);
		configure(rf_pkg::MODE_W'($urandom_range(0, 2)), 2047, 3);
		send_frame(1'b1, LINE_DEPTH);
		configure(rf_pkg::MODE_MED, 3, 3);
		send_frame(1'b0, 6);

		hold_until_drained(DRAIN_CYCLES);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
